>>> sv/yuvbgr_pkg.sv
// Shared types and constants of the 4:2:2 to BGR24 converter.
`timescale 1ns / 1ps

package yuvbgr_pkg;

  localparam logic [7:0] CHROMA_BIAS = 8'd128;
  localparam int         QUEUE_DEPTH = 2;

  localparam logic ORDER_UYVY = 1'b0;
  localparam logic ORDER_YUYV = 1'b1;

  localparam logic [1:0] REG_BYTE_ORDER = 2'd0;
  localparam logic [1:0] REG_ROW_PIXELS = 2'd1;
  localparam logic [1:0] REG_ROW_STRIDE = 2'd2;
  localparam logic [1:0] REG_FRAME_ROWS = 2'd3;

  localparam logic [12:0] RESET_ROW_PIXELS = 13'd640;
  localparam logic [13:0] RESET_ROW_STRIDE = 14'd1280;
  localparam logic [12:0] RESET_FRAME_ROWS = 13'd480;

  typedef struct packed {
    logic        byte_order;
    logic [12:0] row_pixels;
    logic [13:0] row_stride;
    logic [12:0] frame_rows;
  } cfg_t;

  // One macropixel, sorted into components, plus its row and frame marks.
  typedef struct packed {
    logic [7:0] u;
    logic [7:0] v;
    logic [7:0] y0;
    logic [7:0] y1;
    logic       row_end;
    logic       frame_end;
  } pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [7:0] blue_first;
    logic [7:0] green_first;
    logic [7:0] red_first;
    logic [7:0] blue_second;
    logic [7:0] green_second;
    logic [7:0] red_second;
    logic       row_end;
    logic       frame_end;
  } pix_pair_t;

endpackage

>>> sv/yuvbgr_front.sv
// Byte gathering front end: row and frame counting, macropixel assembly.
`timescale 1ns / 1ps

module yuvbgr_front #(
  parameter int MAX_ROW_PIXELS = 4096,
  parameter int MAX_FRAME_ROWS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  yuvbgr_pkg::cfg_t   cfg,
  input  logic               take,
  input  logic [7:0]         data_byte,
  output logic               push,
  output yuvbgr_pkg::pair_t  pair
);
  import yuvbgr_pkg::*;

  localparam int CW  = ($clog2(2 * MAX_ROW_PIXELS + 1) > 14 ?
                        $clog2(2 * MAX_ROW_PIXELS + 1) : 14) + 1;
  localparam int RW  = ($clog2(MAX_FRAME_ROWS + 1) > 13 ?
                        $clog2(MAX_FRAME_ROWS + 1) : 13) + 1;
  localparam int PBW = $clog2(2 * MAX_ROW_PIXELS);
  localparam int RCW = (MAX_FRAME_ROWS > 1) ? $clog2(MAX_FRAME_ROWS) : 1;

  logic [7:0]     held [3];
  logic [PBW-1:0] pos;
  logic [RCW-1:0] row_count;

  logic [CW-1:0] wid, quad, twice, st, st_a, st_b, pos_w, pos1;
  logic [RW-1:0] rows, rows_a, rc1;
  logic          row_done, frame_hit, convert, last_pair;
  logic [1:0]    k;

  always_comb begin
    wid   = (CW'(cfg.row_pixels) > CW'(MAX_ROW_PIXELS)) ?
            CW'(MAX_ROW_PIXELS) : CW'(cfg.row_pixels);
    quad  = (wid >> 1) << 2;
    twice = wid << 1;
    st_a  = (CW'(cfg.row_stride) > CW'(2 * MAX_ROW_PIXELS)) ?
            CW'(2 * MAX_ROW_PIXELS) : CW'(cfg.row_stride);
    st_b  = (st_a < twice) ? twice : st_a;
    st    = (st_b < CW'(4)) ? CW'(4) : st_b;
    rows_a = (cfg.frame_rows == 13'd0) ? RW'(1) : RW'(cfg.frame_rows);
    rows   = (rows_a > RW'(MAX_FRAME_ROWS)) ? RW'(MAX_FRAME_ROWS) : rows_a;

    pos_w     = CW'(pos);
    pos1      = pos_w + CW'(1);
    rc1       = RW'(row_count) + RW'(1);
    row_done  = (pos1 >= st);
    frame_hit = (rc1 >= rows);
    convert   = (pos_w < quad);
    last_pair = (pos1 == quad);
    k         = pos[1:0];
  end

  assign push = take && convert && (k == 2'd3);

  // Sort the bytes by order; the fourth byte comes straight from the input.
  always_comb begin
    if (cfg.byte_order == ORDER_UYVY) begin
      pair.u  = held[0];
      pair.y0 = held[1];
      pair.v  = held[2];
      pair.y1 = data_byte;
    end else begin
      pair.y0 = held[0];
      pair.u  = held[1];
      pair.y1 = held[2];
      pair.v  = data_byte;
    end
    pair.row_end   = last_pair || row_done;
    pair.frame_end = (last_pair || row_done) && frame_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      row_count <= '0;
      held[0]   <= '0;
      held[1]   <= '0;
      held[2]   <= '0;
    end else if (take) begin
      if (convert && k != 2'd3) begin
        held[k] <= data_byte;
      end
      if (row_done) begin
        pos       <= '0;
        row_count <= frame_hit ? '0 : rc1[RCW-1:0];
      end else begin
        pos <= pos1[PBW-1:0];
      end
    end
  end

endmodule

>>> sv/yuvbgr_fifo.sv
// Two-entry queue of gathered macropixels between front and back end.
`timescale 1ns / 1ps

module yuvbgr_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  yuvbgr_pkg::pair_t      wr_data,
  input  logic                   pop,
  output yuvbgr_pkg::pair_t      rd_data,
  output yuvbgr_pkg::q_status_t  status
);
  import yuvbgr_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  pair_t         slots [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] count;

  assign rd_data      = slots[rd_ptr];
  assign status.full  = (count == NW'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + NW'(1);
        2'b01:   count <= count - NW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && status.empty)) else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + NW'(1)))
    else $error("queue count did not advance on push");

endmodule

>>> sv/yuvbgr_back.sv
// Color conversion back end: chroma offsets, then add and clamp.
`timescale 1ns / 1ps

module yuvbgr_back (
  input  logic                   clk,
  input  logic                   rst,
  input  yuvbgr_pkg::pair_t      head,
  input  yuvbgr_pkg::q_status_t  q_status,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output yuvbgr_pkg::pix_pair_t  pix
);
  import yuvbgr_pkg::*;

  function automatic logic [7:0] clamp8(input logic signed [11:0] x);
    if (x < 0) begin
      return 8'd0;
    end else if (x > 12'sd255) begin
      return 8'd255;
    end
    return x[7:0];
  endfunction

  logic signed [9:0]  du, dv;
  logic signed [16:0] m_u;
  logic signed [12:0] m_rg, m_v;

  // stage A: offsets
  logic               a_valid;
  logic signed [10:0] a_u1, a_rg, a_v1;
  logic [7:0]         a_y0, a_y1;
  logic               a_row_end, a_frame_end;

  logic a_load, b_load;

  always_comb begin
    du   = $signed({2'b00, head.u}) - $signed({2'b00, CHROMA_BIAS});
    dv   = $signed({2'b00, head.v}) - $signed({2'b00, CHROMA_BIAS});
    m_u  = (17'(du) <<< 7) + 17'(du);
    m_rg = (13'(du) <<< 1) + 13'(du) + (13'(dv) <<< 2) + (13'(dv) <<< 1);
    m_v  = (13'(dv) <<< 1) + 13'(dv);
  end

  assign b_load = a_valid && (!out_valid || !out_stall);
  assign a_load = !a_valid || b_load;
  assign pop    = a_load && !q_status.empty;

  always_ff @(posedge clk) begin
    if (pop) begin
      a_u1        <= 11'(m_u >>> 6);
      a_rg        <= 11'(m_rg >>> 3);
      a_v1        <= 11'(m_v >>> 1);
      a_y0        <= head.y0;
      a_y1        <= head.y1;
      a_row_end   <= head.row_end;
      a_frame_end <= head.frame_end;
    end
    if (b_load) begin
      pix.blue_first   <= clamp8($signed({4'b0000, a_y0}) + 12'(a_u1));
      pix.green_first  <= clamp8($signed({4'b0000, a_y0}) - 12'(a_rg));
      pix.red_first    <= clamp8($signed({4'b0000, a_y0}) + 12'(a_v1));
      pix.blue_second  <= clamp8($signed({4'b0000, a_y1}) + 12'(a_u1));
      pix.green_second <= clamp8($signed({4'b0000, a_y1}) - 12'(a_rg));
      pix.red_second   <= clamp8($signed({4'b0000, a_y1}) + 12'(a_v1));
      pix.row_end      <= a_row_end;
      pix.frame_end    <= a_frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid <= !q_status.empty;
      end
      if (b_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> sv/yuv422_to_bgr24_converter.sv
// Top level: packed 4:2:2 byte stream in, one BGR24 pixel pair out per macropixel.
// Throughput: one byte per cycle unless the queue is full; a pair per four converted bytes.
// Each pair passes through the queue slot, the offset stage and the output register
//   before it appears on the output.
// Stall on the output backs up through a two-entry queue before the input stalls.
// Reset (synchronous, rst high) clears counters, held bytes, queue and pipeline valids,
//   and loads the register defaults: UYVY, 640 pixels, stride 1280, 480 rows.
`timescale 1ns / 1ps

module yuv422_to_bgr24_converter #(
  parameter int MAX_ROW_PIXELS = 4096,
  parameter int MAX_FRAME_ROWS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  // pixel pair output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  blue_first,
  output logic [7:0]  green_first,
  output logic [7:0]  red_first,
  output logic [7:0]  blue_second,
  output logic [7:0]  green_second,
  output logic [7:0]  red_second,
  output logic        row_end,
  output logic        frame_end
);
  import yuvbgr_pkg::*;

  cfg_t      cfg;
  logic      cfg_write;
  logic [1:0] reg_index;

  logic      take, push, pop;
  pair_t     front_pair, head;
  q_status_t q_status;
  pix_pair_t pix;

  // Configuration registers: word-aligned, one per 4-byte address.
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.byte_order <= ORDER_UYVY;
      cfg.row_pixels <= RESET_ROW_PIXELS;
      cfg.row_stride <= RESET_ROW_STRIDE;
      cfg.frame_rows <= RESET_FRAME_ROWS;
    end else if (cfg_write) begin
      case (reg_index)
        REG_BYTE_ORDER: cfg.byte_order <= pwdata[0];
        REG_ROW_PIXELS: cfg.row_pixels <= pwdata[12:0];
        REG_ROW_STRIDE: cfg.row_stride <= pwdata[13:0];
        REG_FRAME_ROWS: cfg.frame_rows <= pwdata[12:0];
        default:        cfg.byte_order <= cfg.byte_order;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_BYTE_ORDER: prdata = {31'd0, cfg.byte_order};
      REG_ROW_PIXELS: prdata = {19'd0, cfg.row_pixels};
      REG_ROW_STRIDE: prdata = {18'd0, cfg.row_stride};
      REG_FRAME_ROWS: prdata = {19'd0, cfg.frame_rows};
      default:        prdata = 32'd0;
    endcase
  end

  // Hold the input only while the queue has no free slot.
  assign in_stall = q_status.full;
  assign take     = in_valid && !in_stall;

  yuvbgr_front #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS),
    .MAX_FRAME_ROWS(MAX_FRAME_ROWS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .take     (take),
    .data_byte(data_byte),
    .push     (push),
    .pair     (front_pair)
  );

  yuvbgr_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(front_pair),
    .pop    (pop),
    .rd_data(head),
    .status (q_status)
  );

  yuvbgr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pix      (pix)
  );

  assign blue_first   = pix.blue_first;
  assign green_first  = pix.green_first;
  assign red_first    = pix.red_first;
  assign blue_second  = pix.blue_second;
  assign green_second = pix.green_second;
  assign red_second   = pix.red_second;
  assign row_end      = pix.row_end;
  assign frame_end    = pix.frame_end;

endmodule

>>> tb/yuv_pair_checker.sv
// Checker for the 4:2:2 to BGR24 converter: predicts each pixel pair and compares it.
`timescale 1ns / 1ps

module yuv_pair_checker #(
  parameter int MAX_ROW_PIXELS = 4096,
  parameter int MAX_FRAME_ROWS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  blue_first,
  input  logic [7:0]  green_first,
  input  logic [7:0]  red_first,
  input  logic [7:0]  blue_second,
  input  logic [7:0]  green_second,
  input  logic [7:0]  red_second,
  input  logic        row_end,
  input  logic        frame_end,
  output int          fail_count = 0,
  output int          pending = 0
);
  import yuvbgr_pkg::*;

  cfg_t       cfg;
  logic [7:0] held [3];
  int         byte_pos;
  int         row_idx;
  int         reported;
  pix_pair_t  pending_pairs [$];

  function automatic logic [7:0] clip8(input int x);
    if (x < 0) return 8'd0;
    if (x > 255) return 8'd255;
    return x[7:0];
  endfunction

  function automatic string pair_text(input pix_pair_t p);
    return $sformatf("bgr %0d/%0d/%0d bgr %0d/%0d/%0d row_end %0b frame_end %0b",
                     p.blue_first, p.green_first, p.red_first,
                     p.blue_second, p.green_second, p.red_second, p.row_end, p.frame_end);
  endfunction

  // Advance the converter state by one byte; queue the pair on a macropixel's last byte.
  task automatic predict_byte(input logic [7:0] b);
    int        width, pairs, stride, rows;
    int        u, v, y0, y1, du, dv, u1, rg, v1;
    logic      row_done, last_pair;
    pix_pair_t want;
    width  = (cfg.row_pixels > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : int'(cfg.row_pixels);
    pairs  = width / 2;
    stride = (cfg.row_stride > 2 * MAX_ROW_PIXELS) ? 2 * MAX_ROW_PIXELS : int'(cfg.row_stride);
    if (stride < 2 * width) stride = 2 * width;
    if (stride < 4) stride = 4;
    rows = (cfg.frame_rows == 0) ? 1 : int'(cfg.frame_rows);
    if (rows > MAX_FRAME_ROWS) rows = MAX_FRAME_ROWS;
    row_done = (byte_pos + 1 >= stride);

    if (byte_pos < 4 * pairs) begin
      if (byte_pos % 4 < 3) begin
        held[byte_pos % 4] = b;
      end else begin
        last_pair = (byte_pos + 1 == 4 * pairs);
        if (cfg.byte_order == ORDER_UYVY) begin
          u = held[0]; y0 = held[1]; v = held[2]; y1 = b;
        end else begin
          y0 = held[0]; u = held[1]; y1 = held[2]; v = b;
        end
        du = u - 128;
        dv = v - 128;
        // >>> on int floors toward minus infinity
        u1 = (129 * du) >>> 6;
        rg = (3 * du + 6 * dv) >>> 3;
        v1 = (3 * dv) >>> 1;
        want.blue_first   = clip8(y0 + u1);
        want.green_first  = clip8(y0 - rg);
        want.red_first    = clip8(y0 + v1);
        want.blue_second  = clip8(y1 + u1);
        want.green_second = clip8(y1 - rg);
        want.red_second   = clip8(y1 + v1);
        want.row_end      = last_pair || row_done;
        want.frame_end    = (last_pair || row_done) && (row_idx + 1 >= rows);
        pending_pairs.push_back(want);
      end
    end

    if (row_done) begin
      byte_pos = 0;
      row_idx  = (row_idx + 1 >= rows) ? 0 : row_idx + 1;
    end else begin
      byte_pos = byte_pos + 1;
    end
  endtask

  always @(posedge clk) begin
    pix_pair_t got;
    pix_pair_t want;
    if (rst) begin
      cfg = '{ORDER_UYVY, RESET_ROW_PIXELS, RESET_ROW_STRIDE, RESET_FRAME_ROWS};
      held[0] = 8'd0;
      held[1] = 8'd0;
      held[2] = 8'd0;
      byte_pos = 0;
      row_idx = 0;
      reported = 0;
      fail_count = 0;
      pending_pairs.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{blue_first, green_first, red_first, blue_second, green_second, red_second,
                row_end, frame_end};
        if (pending_pairs.size() == 0) begin
          fail_count++;
          if (reported < 10) $display("%0t: unexpected pixel pair: %s", $time, pair_text(got));
          reported++;
        end else begin
          want = pending_pairs.pop_front();
          if (got !== want) begin
            fail_count++;
            if (reported < 10) begin
              $display("%0t: pixel pair mismatch", $time);
              $display("  expected %s", pair_text(want));
              $display("  actual   %s", pair_text(got));
            end
            reported++;
          end
        end
      end

      if (in_valid && !in_stall) predict_byte(data_byte);

      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_BYTE_ORDER: cfg.byte_order = pwdata[0];
          REG_ROW_PIXELS: cfg.row_pixels = pwdata[12:0];
          REG_ROW_STRIDE: cfg.row_stride = pwdata[13:0];
          REG_FRAME_ROWS: cfg.frame_rows = pwdata[12:0];
          default: ;
        endcase
      end
    end
    pending = pending_pairs.size();
  end

endmodule

>>> tb/tb.sv
// Testbench top: drives byte stream, register writes and output stalls, and reports the verdict.
`timescale 1ns / 1ps

module tb;
  import yuvbgr_pkg::*;

  // Cycles with no transaction on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 5000;
  // Hold-off after the last expected pair: covers the output pipeline depth with margin.
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  blue_first;
  logic [7:0]  green_first;
  logic [7:0]  red_first;
  logic [7:0]  blue_second;
  logic [7:0]  green_second;
  logic [7:0]  red_second;
  logic        row_end;
  logic        frame_end;

  int fail_count;
  int pending;
  int gap_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  // Hand-picked bytes: first 16 under UYVY, last 8 under YUYV. They hit both clamp
  // rails on every channel, neutral chroma, and toggle every bit of the byte.
  logic [7:0] directed_bytes [24] = '{
    8'h00, 8'hff, 8'h00, 8'h00,   // U=0 V=0: blue and red floor, green saturates
    8'hff, 8'h00, 8'hff, 8'hff,   // U=255 V=255: opposite rails
    8'h80, 8'h80, 8'h80, 8'h80,   // neutral chroma, mid luma
    8'h01, 8'hfe, 8'hfe, 8'h01,
    8'h00, 8'hff, 8'hff, 8'h00,   // YUYV: Y0 U Y1 V
    8'haa, 8'h55, 8'h55, 8'haa
  };

  always #5 clk = ~clk;

  yuv422_to_bgr24_converter DUT (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .blue_first   (blue_first),
    .green_first  (green_first),
    .red_first    (red_first),
    .blue_second  (blue_second),
    .green_second (green_second),
    .red_second   (red_second),
    .row_end      (row_end),
    .frame_end    (frame_end)
  );

  yuv_pair_checker pair_check (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .blue_first   (blue_first),
    .green_first  (green_first),
    .red_first    (red_first),
    .blue_second  (blue_second),
    .green_second (green_second),
    .red_second   (red_second),
    .row_end      (row_end),
    .frame_end    (frame_end),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Receiver side: stall the output channel at the rate of the current phase.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: any transaction on the byte, pair or register channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER:   begin gap_pct = 85; stall_pct = 0;  end
      IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 85; end
      IDLE_BOTH:     begin gap_pct = 19; stall_pct = 19; end
      default:       begin gap_pct = 0;  stall_pct = 0;  end
    endcase
  endfunction

  // Bias toward the clamp rails and neutral chroma; the rest is uniform.
  function automatic logic [7:0] random_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'($urandom_range(132, 124));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One register write: setup cycle, then access cycle until pready; psel drops for
  // a cycle afterward so back-to-back writes never lower and raise it in one step.
  // Call at a rising edge; returns at a rising edge.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    logic ready_seen;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready_seen = pready;
      @(posedge clk);
    end while (!ready_seen);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic order, input int width, input int stride,
                           input int rows);
    reg_write(REG_BYTE_ORDER, 32'(order));
    reg_write(REG_ROW_PIXELS, 32'(width));
    reg_write(REG_ROW_STRIDE, 32'(stride));
    reg_write(REG_FRAME_ROWS, 32'(rows));
  endtask

  // Present one byte, with random idle cycles first, and hold it until accepted.
  // Stall is sampled at the falling edge, where it is stable for the coming rising edge.
  // Valid stays high on return, so a following byte needs only one assignment.
  task automatic push_byte(input logic [7:0] b);
    logic taken;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  // Drop valid and wait until every predicted pair has come out, then let the
  // pipeline settle; padding bytes may still be in flight when the last pair leaves.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Reprogram all registers while idle, then stream random bytes. With hold_mid the
  // sender stops halfway until the output side has fully drained.
  task automatic run_phase(input logic order, input int width, input int stride,
                           input int rows, input int nbytes, input idle_mode_t mode,
                           input bit hold_mid);
    configure(order, width, stride, rows);
    set_idling(mode);
    for (int i = 0; i < nbytes; i++) begin
      if (hold_mid && i == nbytes / 2) drain_pipeline();
      push_byte(random_byte());
    end
    drain_pipeline();
  endtask

  initial begin
    rst       <= 1'b1;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    in_valid  <= 1'b0;
    data_byte <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: two pairs per row, no padding, two-row frame -> exactly one frame.
    configure(ORDER_UYVY, 4, 8, 2);
    for (int i = 0; i < 16; i++) push_byte(directed_bytes[i]);
    drain_pipeline();
    // Directed YUYV with the smallest frame; rows of zero count as one.
    configure(ORDER_YUYV, 2, 4, 0);
    for (int i = 16; i < 24; i++) push_byte(directed_bytes[i]);
    drain_pipeline();

    // Random phases. Row counters carry across phases, so most reconfigurations
    // land mid-row and the new stride may already be passed.
    run_phase(ORDER_UYVY, 6,    12,    3,    100, IDLE_SENDER,   1'b0);
    run_phase(ORDER_YUYV, 5,    14,    2,    100, IDLE_RECEIVER, 1'b1);  // odd width
    run_phase(ORDER_UYVY, 1,    3,     2,    40,  IDLE_BOTH,     1'b0);  // no pairs at all
    run_phase(ORDER_YUYV, 0,    0,     0,    30,  IDLE_NONE,     1'b0);  // all fields zero
    run_phase(ORDER_UYVY, 8,    2,     1,    120, IDLE_BOTH,     1'b0);  // stride raised
    run_phase(ORDER_YUYV, 2,    4,     1,    120, IDLE_NONE,     1'b0);  // smallest legal
    run_phase(ORDER_UYVY, 7,    20,    4,    120, IDLE_SENDER,   1'b0);
    run_phase(ORDER_YUYV, 4096, 8192,  4096, 120, IDLE_NONE,     1'b0);  // largest legal
    run_phase(ORDER_UYVY, 8191, 16383, 8191, 260, IDLE_RECEIVER, 1'b0);  // all saturate
    run_phase(ORDER_YUYV, 4,    9,     3,    120, IDLE_RECEIVER, 1'b1);  // one padding byte per row
    run_phase(ORDER_UYVY, 10,   24,    2,    100, IDLE_BOTH,     1'b0);
    run_phase(ORDER_YUYV, 3,    6,     5,    100, IDLE_NONE,     1'b0);

    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
